FILE: hw/rtl/gtr_pkg.sv
package gtr_pkg;

  // Fixed glyph geometry and character set size.
  localparam int GLYPH_W    = 8;
  localparam int CHAR_COUNT = 128;
  localparam int CODE_W     = 7;

  localparam logic [7:0]        CODE_NEWLINE = 8'd10;
  localparam logic [CODE_W-1:0] CODE_SPACE   = 7'd32;
  localparam logic [3:0]        MAX_CHANNEL  = 4'd8;

  typedef enum logic [1:0] {
    OP_DRAW   = 2'd0,
    OP_LOAD   = 2'd1,
    OP_CURSOR = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    REG_ENABLED   = 4'd0,
    REG_PITCH     = 4'd1,
    REG_WIDTH     = 4'd2,
    REG_RGB       = 4'd3,
    REG_SIZES     = 4'd4,
    REG_RED_POS   = 4'd5,
    REG_GREEN_POS = 4'd6,
    REG_BLUE_POS  = 4'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_BASE,
    S_COL,
    S_EMIT,
    S_ADV
  } state_t;

  // Operations of the shared offset accumulator.
  typedef enum logic [1:0] {
    OFS_HOLD,
    OFS_LOAD_PRODUCT,
    OFS_ADD_COL,
    OFS_ADD_PITCH
  } ofs_op_t;

  // Keeps the top bits of an 8-bit channel and places them in the pixel word.
  function automatic logic [31:0] pack_channel(logic [7:0] v8, logic [3:0] size,
                                               logic [4:0] pos);
    logic [3:0] sz;
    logic [7:0] v;
    sz = (size > MAX_CHANNEL) ? MAX_CHANNEL : size;
    v  = v8 >> (MAX_CHANNEL - sz);
    if (sz == 4'd0) begin
      return 32'd0;
    end
    return 32'(v) << pos;
  endfunction

endpackage

FILE: hw/rtl/gtr_if.sv
interface gtr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  char_code;
  logic [3:0]  font_row_index;
  logic [7:0]  font_row_bits;
  logic        glyph_present_flag;
  logic [15:0] new_cursor_x;
  logic [15:0] new_cursor_y;

  modport source (output valid, operation, char_code, font_row_index, font_row_bits,
                  glyph_present_flag, new_cursor_x, new_cursor_y, input ready);
  modport sink (input valid, operation, char_code, font_row_index, font_row_bits,
                glyph_present_flag, new_cursor_x, new_cursor_y, output ready);
endinterface

interface gtr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_offset;
  logic [7:0]  pixel_mask;
  logic [31:0] pixel_color;
  logic        last_row;

  modport source (output valid, pixel_offset, pixel_mask, pixel_color, last_row,
                  input ready);
  modport sink (input valid, pixel_offset, pixel_mask, pixel_color, last_row,
                output ready);
endinterface

interface gtr_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/gtr_ram.sv
module gtr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/gtr_offset_unit.sv
module gtr_offset_unit
  import gtr_pkg::*;
(
  input  logic        clk,
  input  ofs_op_t     op,
  input  logic [15:0] pitch,
  input  logic [15:0] line,
  input  logic [15:0] col,
  output logic [31:0] acc
);

  // One accumulator serves the whole glyph: pitch*line, then plus 4*col,
  // then plus pitch for every row that leaves.
  logic [31:0] acc_next;

  always_comb begin
    acc_next = acc;
    case (op)
      OFS_HOLD:         acc_next = acc;
      OFS_LOAD_PRODUCT: acc_next = {16'd0, pitch} * {16'd0, line};
      OFS_ADD_COL:      acc_next = acc + {14'd0, col, 2'b00};
      OFS_ADD_PITCH:    acc_next = acc + {16'd0, pitch};
      default:          acc_next = acc;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

endmodule

FILE: hw/rtl/glyph_text_renderer_top.sv
// Bitmap text renderer for 8-pixel-wide glyphs of GLYPH_H rows. Transactions
// on text_in load font rows, set the cursor or draw a character; each drawn
// character produces GLYPH_H transactions on pixel_out, one per glyph row, with
// the byte offset of the row, the pixel mask (MSB leftmost) and the packed text
// color. After reset the font store is cleared by a sweep over all 128 << RW
// entries (2048 for the default height), during which text_in is not ready;
// configuration writes are taken at any time and always complete at once.
// Font loads, cursor sets, newlines and characters drawn while disabled leave
// text_in ready for the next transaction. A drawn character goes through
// S_BASE, which forms pitch * line in the shared offset unit, S_COL, which adds
// the column and starts the first font read, S_EMIT, where one row leaves per
// cycle from the font store read port while pixel_out does not stall and the
// offset unit adds the pitch, and S_ADV, which advances the cursor.
module glyph_text_renderer_top
  import gtr_pkg::*;
#(
  parameter int GLYPH_H = 16
) (
  input  logic      clk,
  input  logic      rst,
  gtr_in_if.sink    text_in,
  gtr_out_if.source pixel_out,
  gtr_cfg_if.sink   cfg
);

  // Row counter width and font store geometry; one glyph occupies a block of
  // 2**RW entries so the address is simply the code followed by the row.
  localparam int RW         = (GLYPH_H > 1) ? $clog2(GLYPH_H) : 1;
  localparam int FONT_DEPTH = CHAR_COUNT << RW;
  localparam int FA         = CODE_W + RW;

  // Configuration registers.
  logic        enabled;
  logic [15:0] line_pitch;
  logic [11:0] screen_width;
  logic [23:0] text_rgb;
  logic [11:0] channel_sizes;
  logic [4:0]  red_position;
  logic [4:0]  green_position;
  logic [4:0]  blue_position;

  // Sequencer and working state.
  state_t            state, state_next;
  logic [FA-1:0]     clr_addr;
  logic [CHAR_COUNT-1:0] present;
  logic [15:0]       cursor_col;
  logic [15:0]       cursor_line;
  logic [CODE_W-1:0] glyph;
  logic [RW-1:0]     row_cnt;
  logic [31:0]       color;
  ofs_op_t           ofs_op;
  logic [31:0]       ofs_acc;

  // Output register.
  logic        out_valid;
  logic [31:0] out_offset;
  logic [7:0]  out_mask;
  logic [31:0] out_color;
  logic        out_last;

  // Font store ports.
  logic          wr_en;
  logic [FA-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [RW-1:0] rd_row;
  logic [7:0]    rd_data;

  logic in_fire;
  logic load_ok;
  logic is_newline;
  logic out_free;
  logic out_load;
  logic last;
  logic [CODE_W-1:0] glyph_sel;
  logic [15:0] col_adv;

  assign in_fire    = text_in.valid && text_in.ready;
  assign is_newline = (text_in.char_code == CODE_NEWLINE);
  assign load_ok    = !text_in.char_code[7] &&
                      ({28'd0, text_in.font_row_index} < 32'(GLYPH_H));
  // A code outside the table or one whose present bit is clear draws as space.
  assign glyph_sel  = (text_in.char_code[7] ||
                       !present[text_in.char_code[CODE_W-1:0]]) ?
                      CODE_SPACE : text_in.char_code[CODE_W-1:0];
  assign out_free   = !out_valid || pixel_out.ready;
  assign out_load   = (state == S_EMIT) && out_free;
  assign last       = (row_cnt == RW'(GLYPH_H - 1));
  assign col_adv    = cursor_col + 16'(GLYPH_W);

  assign text_in.ready = (state == S_IDLE);
  assign cfg.ready     = 1'b1;

  assign pixel_out.valid        = out_valid;
  assign pixel_out.pixel_offset = out_offset;
  assign pixel_out.pixel_mask   = out_mask;
  assign pixel_out.pixel_color  = out_color;
  assign pixel_out.last_row     = out_last;

  assign wr_addr = (state == S_CLEAR) ? clr_addr :
                   {text_in.char_code[CODE_W-1:0], RW'(text_in.font_row_index)};
  assign wr_data = (state == S_CLEAR) ? 8'd0 : text_in.font_row_bits;

  gtr_ram #(
    .WIDTH (8),
    .DEPTH (FONT_DEPTH)
  ) u_font (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr ({glyph, rd_row}),
    .rd_data (rd_data)
  );

  gtr_offset_unit u_offset (
    .clk   (clk),
    .op    (ofs_op),
    .pitch (line_pitch),
    .line  (cursor_line),
    .col   (cursor_col),
    .acc   (ofs_acc)
  );

  // Next state and the strobes to the font store and offset unit.
  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_row     = row_cnt;
    ofs_op     = OFS_HOLD;
    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (clr_addr == FA'(FONT_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (text_in.operation == OP_LOAD && load_ok) begin
            wr_en = 1'b1;
          end
          if (text_in.operation == OP_DRAW && !is_newline && enabled) begin
            state_next = S_BASE;
          end
        end
      end
      S_BASE: begin
        ofs_op     = OFS_LOAD_PRODUCT;
        state_next = S_COL;
      end
      S_COL: begin
        // The first glyph row is fetched while the column is added in.
        ofs_op     = OFS_ADD_COL;
        rd_en      = 1'b1;
        rd_row     = '0;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        // A row leaves only when the output register can take it; the read
        // data holds while the output side stalls.
        if (out_free) begin
          ofs_op = OFS_ADD_PITCH;
          if (last) begin
            state_next = S_ADV;
          end else begin
            rd_en  = 1'b1;
            rd_row = row_cnt + RW'(1);
          end
        end
      end
      S_ADV: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control state, configuration and cursor.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr       <= '0;
      present        <= '0;
      cursor_col     <= 16'd0;
      cursor_line    <= 16'd0;
      out_valid      <= 1'b0;
      enabled        <= 1'b0;
      line_pitch     <= 16'd4096;
      screen_width   <= 12'd1024;
      text_rgb       <= 24'hFFFFFF;
      channel_sizes  <= 12'h888;
      red_position   <= 5'd16;
      green_position <= 5'd8;
      blue_position  <= 5'd0;
    end else begin
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + FA'(1);
      end

      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ENABLED:   enabled        <= cfg.data[0];
          REG_PITCH:     line_pitch     <= cfg.data[15:0];
          REG_WIDTH:     screen_width   <= cfg.data[11:0];
          REG_RGB:       text_rgb       <= cfg.data[23:0];
          REG_SIZES:     channel_sizes  <= cfg.data[11:0];
          REG_RED_POS:   red_position   <= cfg.data[4:0];
          REG_GREEN_POS: green_position <= cfg.data[4:0];
          REG_BLUE_POS:  blue_position  <= cfg.data[4:0];
          default: ;
        endcase
      end

      if (in_fire) begin
        if (text_in.operation == OP_LOAD && load_ok) begin
          present[text_in.char_code[CODE_W-1:0]] <= text_in.glyph_present_flag;
        end
        if (text_in.operation == OP_CURSOR) begin
          cursor_col  <= text_in.new_cursor_x;
          cursor_line <= text_in.new_cursor_y;
        end
        // A newline moves the cursor whether or not drawing is enabled.
        if (text_in.operation == OP_DRAW && is_newline) begin
          cursor_col  <= 16'd0;
          cursor_line <= cursor_line + 16'(GLYPH_H);
        end
      end

      // Advance by one glyph and wrap when the next glyph would not fit.
      if (state == S_ADV) begin
        if ({1'b0, col_adv} + 17'(GLYPH_W) > {5'd0, screen_width}) begin
          cursor_col  <= 16'd0;
          cursor_line <= cursor_line + 16'(GLYPH_H);
        end else begin
          cursor_col <= col_adv;
        end
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (pixel_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Per-character working registers and the output payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      glyph <= glyph_sel;
    end
    if (state == S_BASE) begin
      color <= pack_channel(text_rgb[23:16], channel_sizes[3:0], red_position) |
               pack_channel(text_rgb[15:8], channel_sizes[7:4], green_position) |
               pack_channel(text_rgb[7:0], channel_sizes[11:8], blue_position);
    end
    if (state == S_COL) begin
      row_cnt <= '0;
    end else if (out_load) begin
      row_cnt <= row_cnt + RW'(1);
    end
    if (out_load) begin
      out_offset <= ofs_acc;
      out_mask   <= rd_data;
      out_color  <= color;
      out_last   <= last;
    end
  end

  // The final row of a glyph is always followed by the cursor advance.
  a_last_then_adv: assert property (@(posedge clk) disable iff (rst)
    (out_load && last) |=> (state == S_ADV))
    else $error("last glyph row not followed by cursor advance");

  // The font store is only written by the clearing sweep or a font load.
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == S_CLEAR || (state == S_IDLE && in_fire)))
    else $error("font store written outside clear or load");

  // Font reads happen only while a glyph is being emitted.
  a_read_states: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (state == S_COL || state == S_EMIT))
    else $error("font store read outside a draw");

  // Every glyph starts emitting from row zero.
  a_row_start: assert property (@(posedge clk) disable iff (rst)
    (state == S_COL) |=> (row_cnt == '0 && state == S_EMIT))
    else $error("glyph emission did not start at row zero");

  // No input is taken while the font store is being cleared.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !text_in.ready)
    else $error("input ready during font clear");

endmodule

FILE: test/glyph_text_renderer_top_test.sv
module glyph_text_renderer_top_test
  import gtr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Glyph height used for both the block and the predictor.
  localparam int GLYPH_H = 16;

  // Operation code that the block has to ignore, and a register index that
  // names no register.
  localparam logic [1:0] OP_NONE    = 2'd3;
  localparam logic [3:0] REG_SPARE  = 4'd15;

  // The settle time covers the time of one full character twice over,
  // so the cursor advance of the last character has finished before any
  // register is touched.
  localparam int SETTLE_CYCLES = 2 * (GLYPH_H + 4);

  // The watchdog limit allows for the font store sweep after reset, the long
  // stall of the pixel side and generous slack.
  localparam int IDLE_LIMIT    = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int HOLD_AT_ROW   = 240;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 70;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  code;
    logic [3:0]  row_index;
    logic [7:0]  row_bits;
    logic        present;
    logic [15:0] cur_x;
    logic [15:0] cur_y;
  } text_item_t;

  typedef struct {
    logic [31:0] offset;
    logic [7:0]  mask;
    logic [31:0] color;
    logic        last;
  } pixel_row_t;

  // Tracks the font store, the cursor and the registers as the block should
  // see them, and keeps the pixel rows still owed by the block in order.
  class text_raster_scoreboard;
    logic [7:0]  font_rows [CHAR_COUNT][GLYPH_H];
    logic        glyph_known [CHAR_COUNT];
    logic [15:0] col;
    logic [15:0] line;
    logic        enable_bit;
    logic [15:0] pitch;
    logic [11:0] width;
    logic [23:0] rgb;
    logic [11:0] sizes;
    logic [4:0]  pos_red;
    logic [4:0]  pos_green;
    logic [4:0]  pos_blue;
    pixel_row_t  owed_rows[$];
    int          errors;

    function new();
      foreach (font_rows[c, r]) font_rows[c][r] = 8'd0;
      foreach (glyph_known[c]) glyph_known[c] = 1'b0;
      col        = 16'd0;
      line       = 16'd0;
      enable_bit = 1'b0;
      pitch      = 16'd4096;
      width      = 12'd1024;
      rgb        = 24'hFFFFFF;
      sizes      = 12'h888;
      pos_red    = 5'd16;
      pos_green  = 5'd8;
      pos_blue   = 5'd0;
      errors     = 0;
    endfunction

    function int pending();
      return owed_rows.size();
    endfunction

    function void write_reg(logic [3:0] idx, logic [31:0] data);
      case (idx)
        REG_ENABLED:   enable_bit = data[0];
        REG_PITCH:     pitch      = data[15:0];
        REG_WIDTH:     width      = data[11:0];
        REG_RGB:       rgb        = data[23:0];
        REG_SIZES:     sizes      = data[11:0];
        REG_RED_POS:   pos_red    = data[4:0];
        REG_GREEN_POS: pos_green  = data[4:0];
        REG_BLUE_POS:  pos_blue   = data[4:0];
        default: ;
      endcase
    endfunction

    // Keeps the top bits of one 8-bit channel and moves them to their place
    // in the pixel word; anything shifted past bit 31 falls off.
    function logic [31:0] place_channel(logic [7:0] level, logic [3:0] bits,
                                        logic [4:0] at);
      int kept;
      kept = (bits > 4'd8) ? 8 : int'(bits);
      if (kept == 0) begin
        return 32'd0;
      end
      return 32'(level >> (8 - kept)) << at;
    endfunction

    function logic [31:0] text_color();
      return place_channel(rgb[23:16], sizes[3:0], pos_red) |
             place_channel(rgb[15:8], sizes[7:4], pos_green) |
             place_channel(rgb[7:0], sizes[11:8], pos_blue);
    endfunction

    // Applies one accepted text transaction and queues the rows it draws.
    function void note_text(text_item_t it);
      logic [6:0] glyph;
      pixel_row_t r;
      case (it.op)
        OP_LOAD: begin
          if (it.code < CHAR_COUNT && it.row_index < GLYPH_H) begin
            font_rows[it.code[6:0]][it.row_index] = it.row_bits;
            glyph_known[it.code[6:0]] = it.present;
          end
        end
        OP_CURSOR: begin
          col  = it.cur_x;
          line = it.cur_y;
        end
        OP_DRAW: begin
          if (it.code == CODE_NEWLINE) begin
            col  = 16'd0;
            line = line + 16'(GLYPH_H);
          end else if (enable_bit) begin
            if (it.code >= CHAR_COUNT || !glyph_known[it.code[6:0]]) begin
              glyph = CODE_SPACE;
            end else begin
              glyph = it.code[6:0];
            end
            for (int row = 0; row < GLYPH_H; row++) begin
              r.offset = 32'(pitch) * (32'(line) + 32'(row)) + 32'(col) * 32'd4;
              r.mask   = font_rows[glyph][row];
              r.color  = text_color();
              r.last   = (row == GLYPH_H - 1);
              owed_rows.push_back(r);
            end
            col = col + 16'(GLYPH_W);
            if (int'(col) + GLYPH_W > int'(width)) begin
              col  = 16'd0;
              line = line + 16'(GLYPH_H);
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_row(pixel_row_t got);
      pixel_row_t want;
      if (owed_rows.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: unexpected pixel row offset=%h mask=%h color=%h last=%b",
                   $realtime, got.offset, got.mask, got.color, got.last);
        end
        return;
      end
      want = owed_rows.pop_front();
      if (got.offset !== want.offset || got.mask !== want.mask ||
          got.color !== want.color || got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("%0t: pixel row mismatch: expected offset=%h mask=%h color=%h last=%b",
                   $realtime, want.offset, want.mask, want.color, want.last);
          $display("%0t:                      actual offset=%h mask=%h color=%h last=%b",
                   $realtime, got.offset, got.mask, got.color, got.last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  gtr_in_if  text_in();
  gtr_out_if pixel_out();
  gtr_cfg_if cfg();

  text_raster_scoreboard raster_sb;

  int text_gap_max;
  int idle_cycles;

  glyph_text_renderer_top #(
    .GLYPH_H(GLYPH_H)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_in),
    .pixel_out(pixel_out),
    .cfg      (cfg)
  );

  always #1 clk = ~clk;

  // Watchdog: any cycle with a transaction on one of the three channels
  // restarts the count, so only a block that has stopped moving trips it.
  always @(posedge clk) begin
    if ((text_in.valid && text_in.ready) || (pixel_out.valid && pixel_out.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // All fields random; the callers override what the operation needs. This
  // also toggles the fields that an operation does not look at.
  function automatic text_item_t noise_item();
    text_item_t it;
    it.op        = 2'($urandom_range(0, 3));
    it.code      = 8'($urandom);
    it.row_index = 4'($urandom);
    it.row_bits  = 8'($urandom);
    it.present   = 1'($urandom);
    it.cur_x     = 16'($urandom);
    it.cur_y     = 16'($urandom);
    return it;
  endfunction

  // Characters mostly come from a small set so that draws often hit glyphs
  // that were loaded; the rest covers the whole code range, including codes
  // of 128 and above.
  function automatic logic [7:0] pick_code();
    if ($urandom_range(0, 3) != 0) begin
      return 8'($urandom_range(32, 47));
    end
    return 8'($urandom);
  endfunction

  function automatic text_item_t rand_text_item();
    text_item_t it;
    int unsigned pick;
    it   = noise_item();
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      it.op      = OP_LOAD;
      it.code    = pick_code();
      it.present = ($urandom_range(0, 4) != 0);
    end else if (pick < 75) begin
      it.op   = OP_DRAW;
      it.code = pick_code();
    end else if (pick < 85) begin
      it.op = OP_CURSOR;
      if ($urandom_range(0, 2) != 0) begin
        it.cur_x = 16'($urandom_range(0, 4095));
        it.cur_y = 16'($urandom_range(0, 1023));
      end
    end else if (pick < 93) begin
      it.op   = OP_DRAW;
      it.code = CODE_NEWLINE;
    end else begin
      it.op = OP_NONE;
    end
    return it;
  endfunction

  // Zero, the field maximum or anything in between.
  function automatic logic [31:0] corner_pick(logic [31:0] hi);
    case ($urandom_range(0, 3))
      0:       return 32'd0;
      1:       return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  // Offers one transaction on text_in. The sender is left parked on the
  // rising edge of acceptance with valid still high, so that a following
  // transaction with no gap keeps valid high without a glitch.
  task automatic send_text(text_item_t it);
    int gap;
    gap = $urandom_range(0, text_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      text_in.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    text_in.valid              <= 1'b1;
    text_in.operation          <= it.op;
    text_in.char_code          <= it.code;
    text_in.font_row_index     <= it.row_index;
    text_in.font_row_bits      <= it.row_bits;
    text_in.glyph_present_flag <= it.present;
    text_in.new_cursor_x       <= it.cur_x;
    text_in.new_cursor_y       <= it.cur_y;
    do @(posedge clk); while (!text_in.ready);
    raster_sb.note_text(it);
  endtask

  task automatic draw_char(logic [7:0] code);
    text_item_t it;
    it      = noise_item();
    it.op   = OP_DRAW;
    it.code = code;
    send_text(it);
  endtask

  task automatic load_row(logic [7:0] code, logic [3:0] row, logic [7:0] bits,
                          logic flag);
    text_item_t it;
    it           = noise_item();
    it.op        = OP_LOAD;
    it.code      = code;
    it.row_index = row;
    it.row_bits  = bits;
    it.present   = flag;
    send_text(it);
  endtask

  task automatic move_cursor(logic [15:0] x, logic [15:0] y);
    text_item_t it;
    it       = noise_item();
    it.op    = OP_CURSOR;
    it.cur_x = x;
    it.cur_y = y;
    send_text(it);
  endtask

  // Drops valid, then waits until every owed row has come out and the block
  // has had time to finish its last cursor update.
  task automatic drain_text();
    @(negedge clk);
    text_in.valid <= 1'b0;
    while (raster_sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    raster_sb.write_reg(idx, data);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Writes all eight registers. Bits above each field carry random junk,
  // which the block has to ignore.
  task automatic program_regs(logic en, logic [15:0] pitch, logic [11:0] width,
                              logic [23:0] rgb, logic [11:0] sizes, logic [4:0] rp,
                              logic [4:0] gp, logic [4:0] bp);
    write_reg(REG_ENABLED,   {$urandom} & ~32'h1    | 32'(en));
    write_reg(REG_PITCH,     {$urandom} & ~32'hFFFF | 32'(pitch));
    write_reg(REG_WIDTH,     {$urandom} & ~32'hFFF  | 32'(width));
    write_reg(REG_RGB,       {$urandom} & ~32'hFFFFFF | 32'(rgb));
    write_reg(REG_SIZES,     {$urandom} & ~32'hFFF  | 32'(sizes));
    write_reg(REG_RED_POS,   {$urandom} & ~32'h1F   | 32'(rp));
    write_reg(REG_GREEN_POS, {$urandom} & ~32'h1F   | 32'(gp));
    write_reg(REG_BLUE_POS,  {$urandom} & ~32'h1F   | 32'(bp));
  endtask

  // Pixel side. Each row waits a random number of cycles before ready goes
  // high, with stretches of no waiting at all. Once, well into the run, the
  // pixel side refuses rows for a long stretch while text keeps coming, so
  // the block backs up and stalls text_in.
  initial begin
    pixel_row_t got;
    int         rows_taken;
    int         gap;
    bit         quiet;
    bit         held;
    rows_taken = 0;
    quiet      = 1'b0;
    held       = 1'b0;
    pixel_out.ready = 1'b0;
    @(negedge rst);
    @(negedge clk);
    forever begin
      if (rows_taken % 48 == 0) begin
        quiet = ($urandom_range(0, 2) == 0);
      end
      gap = quiet ? 0 : $urandom_range(0, 10);
      if (!held && rows_taken == HOLD_AT_ROW) begin
        gap  = gap + HOLD_CYCLES;
        held = 1'b1;
      end
      if (gap > 0) begin
        pixel_out.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pixel_out.ready <= 1'b1;
      do @(posedge clk); while (!pixel_out.valid);
      got.offset = pixel_out.pixel_offset;
      got.mask   = pixel_out.pixel_mask;
      got.color  = pixel_out.pixel_color;
      got.last   = pixel_out.last_row;
      raster_sb.check_row(got);
      rows_taken++;
      @(negedge clk);
    end
  end

  // Text and configuration side, and the final verdict.
  initial begin
    raster_sb    = new();
    clk          = 1'b0;
    rst          = 1'b1;
    idle_cycles  = 0;
    text_gap_max = 10;

    text_in.valid              = 1'b0;
    text_in.operation          = OP_DRAW;
    text_in.char_code          = 8'd0;
    text_in.font_row_index     = 4'd0;
    text_in.font_row_bits      = 8'd0;
    text_in.glyph_present_flag = 1'b0;
    text_in.new_cursor_x       = 16'd0;
    text_in.new_cursor_y       = 16'd0;
    cfg.valid = 1'b0;
    cfg.index = REG_ENABLED;
    cfg.data  = 32'd0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Extreme settings first: widest pitch and screen, white text, channel
    // sizes above eight, and fields pushed to the top and bottom of the word
    // so that the red and blue bits mostly fall off.
    program_regs(1'b1, 16'hFFFF, 12'hFFF, 24'hFFFFFF, 12'hFFF, 5'd31, 5'd0, 5'd31);
    write_reg(REG_SPARE, $urandom);

    // Nothing is loaded yet, so the character draws as an all-empty space.
    draw_char(8'd65);
    // Space rows are loaded with a cleared present bit; space still draws.
    load_row(8'd32, 4'd0, 8'hFF, 1'b0);
    load_row(8'd32, 4'd15, 8'h81, 1'b0);
    load_row(8'd65, 4'd0, 8'h80, 1'b1);
    load_row(8'd65, 4'd15, 8'h01, 1'b1);
    // A load beyond the character set is dropped.
    load_row(8'd200, 4'd3, 8'hAA, 1'b1);
    // A glyph loaded with its present bit clear still draws as space.
    load_row(8'd127, 4'd7, 8'h3C, 1'b0);
    // Cursor at the far corner: the offset and the column both wrap.
    move_cursor(16'hFFFF, 16'hFFFF);
    draw_char(8'd65);
    draw_char(8'd200);
    draw_char(8'd127);
    draw_char(CODE_NEWLINE);
    begin
      text_item_t it;
      it    = noise_item();
      it.op = OP_NONE;
      send_text(it);
    end
    // After the next character the following glyph would not fit, so the line wraps.
    move_cursor(16'd4080, 16'd0);
    draw_char(8'd65);
    draw_char(8'd0);
    load_row(8'd0, 4'd0, 8'h55, 1'b1);
    draw_char(8'd0);
    drain_text();

    // Disabled with every register at zero: only the newline moves the
    // cursor, and the later draws show where it went.
    program_regs(1'b0, 16'd0, 12'd0, 24'd0, 12'd0, 5'd0, 5'd0, 5'd0);
    draw_char(8'd65);
    draw_char(CODE_NEWLINE);
    draw_char(8'd255);
    drain_text();

    // A zero screen width wraps after every character.
    program_regs(1'b1, 16'd1, 12'd0, 24'($urandom), 12'h888, 5'd24, 5'd12, 5'd0);
    draw_char(8'd65);
    draw_char(8'd32);
    draw_char(CODE_NEWLINE);
    draw_char(8'd65);
    drain_text();

    // Random phases, each with its own register set. One phase runs
    // disabled so that draws and newlines mix without output.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      program_regs(phase != 2, 16'(corner_pick(32'hFFFF)), 12'(corner_pick(32'hFFF)),
                   24'(corner_pick(32'hFFFFFF)), 12'(corner_pick(32'hFFF)),
                   5'(corner_pick(32'd31)), 5'(corner_pick(32'd31)),
                   5'(corner_pick(32'd31)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 20 == 0) begin
          text_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
        end
        send_text(rand_text_item());
      end
      drain_text();
    end

    if (raster_sb.errors == 0 && raster_sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
